### design/mvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants, codes and widths of the matrix-vector multiply engine.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_DIM  = 16;
   localparam int LEN_CAP  = (MAX_DIM < 16) ? MAX_DIM : 16;

   localparam int LEN_W    = 5;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = 40;
   localparam int FRAC_W   = 8;
   localparam int CSR_AW   = 2;

   localparam int IDX_W    = $clog2(LEN_CAP);
   localparam int VEC_AW   = $clog2(MAX_DIM);
   localparam int MAT_AW   = $clog2(MAX_DIM * MAX_DIM);

   localparam logic [1:0] ACT_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] ACT_WRITE_VECTOR = 2'd1;
   localparam logic [1:0] ACT_COMPUTE      = 2'd2;

   localparam logic [CSR_AW-1:0] REG_IN_LENGTH  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_OUT_LENGTH = 2'd1;
   localparam logic [CSR_AW-1:0] REG_TRANSPOSE  = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_j;
      logic             zero;
      logic             last_row;
      logic [POS_W-1:0] index;
   } mvm_beat_type;

endpackage
`default_nettype wire

### design/mvm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/matrix_vector_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Matrix-vector multiply engine with optional transpose, one shared MAC.
// ----------------------------------------------------------------------------
// Write items are accepted back to back while the engine is idle.
// A compute item runs its MACs through the shared multiplier and accumulator;
// with n = min(in_length,16), each result sums max(n,1) products, and a row
// starts only when the result register is empty or being taken; a compute
// with out_length zero returns no result and leaves the engine idle.
// Reset is synchronous; it restores the length and transpose registers and
// clears control state; store contents are undefined until written.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [1:0]                           req_action,
   input  wire [mvm_pkg::POS_W-1:0]            req_row,
   input  wire [mvm_pkg::POS_W-1:0]            req_col,
   input  wire [mvm_pkg::POS_W-1:0]            req_vec_index,
   input  wire signed [mvm_pkg::DATA_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [mvm_pkg::POS_W-1:0]           rsp_out_index,
   output logic signed [mvm_pkg::DATA_W-1:0]   rsp_out_value,
   output logic                                rsp_last,
   input  wire                                 csr_wr_en,
   input  wire [mvm_pkg::CSR_AW-1:0]           csr_addr,
   input  wire [mvm_pkg::LEN_W-1:0]            csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ROW   = 4'b0010,
      S_MAC   = 4'b0100,
      S_DRAIN = 4'b1000
   } mvm_state_type;

   mvm_state_type                      state_ff, state_in;
   logic [mvm_pkg::LEN_W-1:0]          in_length_ff, out_length_ff;
   logic                               transpose_ff;
   logic [mvm_pkg::IDX_W-1:0]          i_ff, i_in, j_ff, j_in;
   mvm_pkg::mvm_beat_type              beat_ff, mac_ff, beat;
   logic signed [mvm_pkg::PROD_W-1:0]  prod_ff;
   logic signed [mvm_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                               rsp_valid_ff;
   logic [mvm_pkg::POS_W-1:0]          rsp_index_ff;
   logic signed [mvm_pkg::DATA_W-1:0]  rsp_value_ff, sat_value;
   logic                               rsp_last_ff;

   logic [mvm_pkg::LEN_W-1:0]          n_in, n_out;
   logic                               accept, slot_free, issue, load_rsp, fits;
   logic                               mat_wr, vec_wr;
   logic [mvm_pkg::MAT_AW-1:0]         mat_wr_addr, mat_rd_addr;
   logic [mvm_pkg::VEC_AW-1:0]         vec_wr_addr, vec_rd_addr;
   logic [mvm_pkg::DATA_W-1:0]         mat_rd_data, vec_rd_data;

   assign n_in  = (in_length_ff  > mvm_pkg::LEN_W'(mvm_pkg::LEN_CAP)) ?
                  mvm_pkg::LEN_W'(mvm_pkg::LEN_CAP) : in_length_ff;
   assign n_out = (out_length_ff > mvm_pkg::LEN_W'(mvm_pkg::LEN_CAP)) ?
                  mvm_pkg::LEN_W'(mvm_pkg::LEN_CAP) : out_length_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign issue     = ((state_ff == S_ROW) && slot_free) || (state_ff == S_MAC);
   assign load_rsp  = mac_ff.valid && mac_ff.last_j;

   assign mat_wr      = accept && (req_action == mvm_pkg::ACT_WRITE_MATRIX) &&
                        (int'(req_row) < mvm_pkg::MAX_DIM) &&
                        (int'(req_col) < mvm_pkg::MAX_DIM);
   assign vec_wr      = accept && (req_action == mvm_pkg::ACT_WRITE_VECTOR) &&
                        (int'(req_vec_index) < mvm_pkg::MAX_DIM);
   assign mat_wr_addr = mvm_pkg::MAT_AW'(int'(req_row) * mvm_pkg::MAX_DIM + int'(req_col));
   assign vec_wr_addr = mvm_pkg::VEC_AW'(req_vec_index);
   assign mat_rd_addr = transpose_ff ?
                        mvm_pkg::MAT_AW'(int'(j_ff) * mvm_pkg::MAX_DIM + int'(i_ff)) :
                        mvm_pkg::MAT_AW'(int'(i_ff) * mvm_pkg::MAX_DIM + int'(j_ff));
   assign vec_rd_addr = mvm_pkg::VEC_AW'(j_ff);

   mvm_ram #(.WIDTH(mvm_pkg::DATA_W), .DEPTH(mvm_pkg::MAX_DIM * mvm_pkg::MAX_DIM)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_wr),
      .wr_addr (mat_wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data)
   );

   mvm_ram #(.WIDTH(mvm_pkg::DATA_W), .DEPTH(mvm_pkg::MAX_DIM)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr),
      .wr_addr (vec_wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd_data)
   );

   always_comb begin
      beat.valid    = issue;
      beat.first    = (state_ff == S_ROW);
      beat.zero     = (n_in == '0);
      beat.last_j   = beat.zero || (mvm_pkg::LEN_W'(j_ff) == n_in - 5'd1);
      beat.last_row = (mvm_pkg::LEN_W'(i_ff) == n_out - 5'd1);
      beat.index    = mvm_pkg::POS_W'(i_ff);
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == mvm_pkg::ACT_COMPUTE)) begin
               i_in = '0;
               if (n_out != '0) begin
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            if (issue) begin
               j_in     = mvm_pkg::IDX_W'(1);
               state_in = beat.last_j ? S_DRAIN : S_MAC;
            end
         end
         S_MAC: begin
            j_in = j_ff + mvm_pkg::IDX_W'(1);
            if (beat.last_j) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            j_in = '0;
            if (load_rsp) begin
               if (mac_ff.last_row) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + mvm_pkg::IDX_W'(1);
                  state_in = S_ROW;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      acc_in = mac_ff.first ? mvm_pkg::ACC_W'(prod_ff) : acc_ff + mvm_pkg::ACC_W'(prod_ff);
      fits   = (&acc_in[mvm_pkg::ACC_W-1:23]) || !(|acc_in[mvm_pkg::ACC_W-1:23]);
      if (fits) begin
         sat_value = acc_in[23:mvm_pkg::FRAC_W];
      end else if (acc_in[mvm_pkg::ACC_W-1]) begin
         sat_value = 16'sh8000;
      end else begin
         sat_value = 16'sh7FFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_length_ff  <= mvm_pkg::LEN_RESET;
         out_length_ff <= mvm_pkg::LEN_RESET;
         transpose_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         beat_ff       <= '0;
         mac_ff        <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         beat_ff  <= beat;
         mac_ff   <= beat_ff;
         if (csr_wr_en) begin
            unique case (csr_addr)
               mvm_pkg::REG_IN_LENGTH:  in_length_ff  <= csr_wr_data;
               mvm_pkg::REG_OUT_LENGTH: out_length_ff <= csr_wr_data;
               mvm_pkg::REG_TRANSPOSE:  transpose_ff  <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (mac_ff.valid) begin
            acc_ff <= acc_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_ff.valid) begin
         if (beat_ff.zero) begin
            prod_ff <= '0;
         end else begin
            prod_ff <= $signed(mat_rd_data) * $signed(vec_rd_data);
         end
      end
      if (load_rsp) begin
         rsp_index_ff <= mac_ff.index;
         rsp_value_ff <= sat_value;
         rsp_last_ff  <= mac_ff.last_row;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwrote a stalled item");

   a_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (state_ff == S_DRAIN))
      else $error("result completed outside drain");

   a_row_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> (!beat_ff.valid && !mac_ff.valid))
      else $error("row started with MAC pipeline busy");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && mac_ff.last_row) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after final result");

endmodule
`default_nettype wire
